// ===== sv/sorted_key_value_table_defines.svh =====
// Assertion macros for the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SKV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define SKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/skvt_pkg.sv =====
package skvt_pkg;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_UPDATE = 3'd1;
  localparam logic [2:0] FN_UPSERT = 3'd2;
  localparam logic [2:0] FN_ERASE  = 3'd3;
  localparam logic [2:0] FN_HAS    = 3'd4;
  localparam logic [2:0] FN_GETKEY = 3'd5;
  localparam logic [2:0] FN_GETPOS = 3'd6;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [63:0] value;
    logic [7:0]  position;
  } skvt_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] key_out;
    logic [63:0] value_out;
    logic [8:0]  count;
    logic        is_empty;
  } skvt_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, run search
    logic commit;   // apply shift/write
    logic respond;  // drive result strobe
  } skvt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ok;
  } skvt_sts_t;

endpackage

// ===== sv/sorted_key_value_table.sv =====
// Sorted key/value table, parallel compare cells with shift-in/close-up.
// After the start transfer a request passes the commit and respond states.
// A new request is taken only from idle; busy covers the whole request.
// Receiver cannot stall: each result shows for exactly one cycle on out_valid.
// Reset (rst_n low, synchronous): count to zero, capacity to 256; stored
// entries are not cleared, no clearing pass needed.
module sorted_key_value_table import skvt_pkg::*; #(
  parameter int DEPTH       = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  skvt_in_t   in_data,
  output logic       out_valid,
  output skvt_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);
  logic [8:0] cap_r;
  skvt_cmd_t  cmd;
  skvt_sts_t  sts;

  // capacity register; transfers only while idle
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n)                      cap_r <= 9'd256;
    else if (cfg_valid && cfg_ready) cap_r <= cfg_data;
  end

  skvt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .cmd(cmd), .busy(busy), .strobe(out_valid)
  );

  skvt_datapath #(
    .DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(in_data), .cap(cap_r),
    .sts(sts), .res(out_data)
  );
endmodule

// ===== sv/skvt_datapath.sv =====
module skvt_datapath import skvt_pkg::*; #(
  parameter int DEPTH       = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  skvt_cmd_t cmd,
  input  skvt_in_t  req,
  input  logic [8:0] cap,
  output skvt_sts_t sts,
  output skvt_out_t res
);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0]   keys_r   [DEPTH];
  logic [VALUE_WIDTH-1:0] vals_r   [DEPTH];
  logic [KEY_WIDTH-1:0]   keys_nxt [DEPTH];
  logic [VALUE_WIDTH-1:0] vals_nxt [DEPTH];
  logic [CW-1:0]          cnt_r;

  // captured request and per-cell search results
  logic [2:0]             func_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [DEPTH-1:0]       hit_r, gt_r;
  logic [7:0]             pos_r;
  logic                   ok_r;
  logic [KEY_WIDTH-1:0]   kout_r;
  logic [VALUE_WIDTH-1:0] vout_r;

  logic [KEY_WIDTH-1:0]   kin;
  logic [VALUE_WIDTH-1:0] vin;
  logic [DEPTH-1:0]       live, hit_c, gt_c;
  logic [CW-1:0]          lim;
  logic                   found, full, do_ins, do_upd, do_era;
  logic                   ok_c;
  logic [KEY_WIDTH-1:0]   kout_c;
  logic [VALUE_WIDTH-1:0] vout_c;
  logic [DEPTH-1:0]       ins_at, from_hit;
  logic                   hit_seen;

  always_comb begin
    kin = KEY_WIDTH'(req.key);
    vin = VALUE_WIDTH'(req.value);
    for (int i = 0; i < DEPTH; i++) begin
      live[i]  = CW'(i) < cnt_r;
      hit_c[i] = live[i] && keys_r[i] == kin;
      gt_c[i]  = live[i] && keys_r[i] > kin;
    end
  end

  // read data for the two get functions, captured with the request
  always_comb begin
    kout_c = '0;
    vout_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (req.func == FN_GETKEY && hit_c[i]) vout_c = vals_r[i];
      if (req.func == FN_GETPOS && 32'(req.position) == i && live[i]) begin
        kout_c = keys_r[i];
        vout_c = vals_r[i];
      end
    end
  end

  always_comb begin
    lim = (32'(cap) < DEPTH) ? CW'(cap) : CW'(DEPTH);
    found = |hit_r;
    full = cnt_r >= lim;
    do_upd = found && (func_r == FN_UPDATE || func_r == FN_UPSERT);
    do_ins = !found && !full && (func_r == FN_INSERT || func_r == FN_UPSERT);
    do_era = found && func_r == FN_ERASE;
  end

  always_comb begin
    case (func_r)
      FN_INSERT: ok_c = do_ins;
      FN_UPDATE: ok_c = do_upd;
      FN_UPSERT: ok_c = do_upd || do_ins;
      FN_ERASE:  ok_c = do_era;
      FN_HAS, FN_GETKEY: ok_c = found;
      FN_GETPOS: ok_c = 32'(pos_r) < 32'(cnt_r) && 32'(pos_r) < DEPTH;
      default:   ok_c = 1'b0;
    endcase
  end
  assign sts.ok = ok_r;

  // next cell contents: shift up above the insert point, close up after an erase, write the value on an update
  always_comb begin
    hit_seen = 1'b0;
    ins_at   = gt_r & ~(gt_r << 1);
    for (int i = 0; i < DEPTH; i++) begin
      hit_seen    = hit_seen | hit_r[i];
      from_hit[i] = hit_seen;
      // no greater key: new entry goes at the end
      if (!(|gt_r) && CW'(i) == cnt_r) ins_at[i] = 1'b1;
    end
    keys_nxt = keys_r;
    vals_nxt = vals_r;
    for (int i = 1; i < DEPTH; i++) begin
      if (do_ins && gt_r[i-1]) begin
        keys_nxt[i] = keys_r[i-1];
        vals_nxt[i] = vals_r[i-1];
      end
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (do_era && from_hit[i]) begin
        keys_nxt[i] = keys_r[i+1];
        vals_nxt[i] = vals_r[i+1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins && ins_at[i]) begin
        keys_nxt[i] = key_r;
        vals_nxt[i] = val_r;
      end
      if (do_upd && hit_r[i]) vals_nxt[i] = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= req.func;
      key_r  <= kin;
      val_r  <= vin;
      pos_r  <= req.position;
      hit_r  <= hit_c;
      gt_r   <= gt_c;
      kout_r <= kout_c;
      vout_r <= vout_c;
    end
    if (cmd.commit) begin
      ok_r   <= ok_c;
      keys_r <= keys_nxt;
      vals_r <= vals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.commit) begin
      if (do_ins)      cnt_r <= cnt_r + CW'(1);
      else if (do_era) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_comb begin
    res.ok        = ok_r;
    res.key_out   = 32'(kout_r);
    res.value_out = 64'(vout_r);
    res.count     = 9'(cnt_r);
    res.is_empty  = cnt_r == '0;
  end

endmodule

// ===== sv/skvt_ctrl.sv =====
module skvt_ctrl import skvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  skvt_sts_t sts,
  output skvt_cmd_t cmd,
  output logic      busy,
  output logic      strobe
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy        = state_r != ST_IDLE;
  assign cmd.load    = state_r == ST_IDLE && start;
  assign cmd.commit  = state_r == ST_EXEC;
  assign cmd.respond = state_r == ST_RESP;
  assign strobe      = cmd.respond;

  `include "sorted_key_value_table_defines.svh"
  `SKV_ASSERT_NEXT(a_load_exec, cmd.load, state_r == ST_EXEC)
  `SKV_ASSERT_NEXT(a_exec_resp, cmd.commit, strobe)
  `SKV_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.commit, cmd.respond}))
  `SKV_ASSERT_IMPL(a_ok_known, strobe, !$isunknown(sts.ok))
  `SKV_ASSERT_NEXT(a_resp_idle, strobe, !busy)
endmodule

// ===== sim/tb_sorted_key_value_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_value_table;
  import skvt_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;

  // Golden copy of the table plus a queue of expected responses.
  class table_scoreboard;
    logic [31:0] keys[TABLE_DEPTH];
    logic [63:0] vals[TABLE_DEPTH];
    int unsigned used;
    int unsigned cap;
    skvt_out_t pending[$];
    int unsigned errors;

    function void clear();
      used = 0;
      cap = 256;
      errors = 0;
      pending.delete();
    endfunction

    function int locate(logic [31:0] k);
      for (int i = 0; i < used; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function bit add_entry(logic [31:0] k, logic [63:0] v);
      int lim;
      int pos;
      lim = (cap < TABLE_DEPTH) ? cap : TABLE_DEPTH;
      if (used >= lim || locate(k) >= 0) return 0;
      pos = 0;
      while (pos < used && keys[pos] <= k) pos++;
      for (int j = used; j > pos; j--) begin
        keys[j] = keys[j-1];
        vals[j] = vals[j-1];
      end
      keys[pos] = k;
      vals[pos] = v;
      used++;
      return 1;
    endfunction

    // Apply one accepted request and queue its response.
    function void note_request(skvt_in_t rq);
      skvt_out_t rs;
      int p;
      rs = '0;
      p = locate(rq.key);
      case (rq.func)
        FN_INSERT: rs.ok = add_entry(rq.key, rq.value);
        FN_UPDATE: if (p >= 0) begin
          vals[p] = rq.value;
          rs.ok = 1;
        end
        FN_UPSERT: if (p >= 0) begin
          vals[p] = rq.value;
          rs.ok = 1;
        end else begin
          rs.ok = add_entry(rq.key, rq.value);
        end
        FN_ERASE: if (p >= 0) begin
          for (int i = p; i + 1 < used; i++) begin
            keys[i] = keys[i+1];
            vals[i] = vals[i+1];
          end
          used--;
          rs.ok = 1;
        end
        FN_HAS: rs.ok = (p >= 0);
        FN_GETKEY: if (p >= 0) begin
          rs.ok = 1;
          rs.value_out = vals[p];
        end
        FN_GETPOS: if (rq.position < used) begin
          rs.ok = 1;
          rs.key_out = keys[rq.position];
          rs.value_out = vals[rq.position];
        end
        default: ;
      endcase
      rs.count = used[8:0];
      rs.is_empty = (used == 0);
      pending.push_back(rs);
    endfunction

    function void check_response(skvt_out_t got);
      skvt_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok || got.key_out !== want.key_out ||
          got.value_out !== want.value_out || got.count !== want.count ||
          got.is_empty !== want.is_empty) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  skvt_in_t in_data = '0;
  logic out_valid;
  skvt_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;

  table_scoreboard sb;
  int unsigned cycles = 0;
  logic [31:0] key_pool[16];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  sorted_key_value_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Responses are sampled on the edge that ends their cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_response(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // One request transfer: start stays high until an edge with busy low.
  // busy is read mid-cycle so the accepting edge is known ahead of time.
  task automatic send_request(logic [2:0] fn, logic [31:0] k, logic [63:0] v,
                              logic [7:0] pos);
    skvt_in_t rq;
    int gap;
    rq.func = fn;
    rq.key = k;
    rq.value = v;
    rq.position = pos;
    start <= 1;
    in_data <= rq;
    @(negedge clk);
    while (busy) @(negedge clk);
    sb.note_request(rq);
    @(posedge clk);
    // with no gap, start stays high and the next request follows at once
    gap = pick_gap();
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Capacity writes only once all responses are back and the block has settled.
  task automatic set_capacity(logic [8:0] c);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.cap = c;
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic random_phase(int n, int fill_bias);
    logic [2:0] fn;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < fill_bias) fn = FN_INSERT;
      else fn = 3'($urandom_range(0, 7));
      send_request(fn, pick_key(), {$urandom(), $urandom()},
                   8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 20)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 16; i++) key_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table, key and value extremes, every function.
    send_request(FN_GETPOS, 32'h0, 64'h0, 8'd0);
    send_request(FN_ERASE, 32'h5, 64'h0, 8'd0);
    send_request(FN_INSERT, 32'hFFFF_FFFF, '1, 8'd0);
    send_request(FN_INSERT, 32'h0, 64'h0, 8'd0);
    send_request(FN_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 8'd0);
    send_request(FN_INSERT, 32'h0, 64'h1, 8'd0);          // duplicate
    send_request(FN_UPDATE, 32'h1234, 64'h1, 8'd0);       // absent
    send_request(FN_UPDATE, 32'h0, 64'hA5A5_5A5A_F00F_0FF0, 8'd0);
    send_request(FN_UPSERT, 32'h0, 64'h2, 8'd0);
    send_request(FN_UPSERT, 32'h10, 64'h3, 8'd0);
    send_request(FN_HAS, 32'h10, 64'h0, 8'd0);
    send_request(FN_HAS, 32'h11, 64'h0, 8'd0);
    send_request(FN_GETKEY, 32'hFFFF_FFFF, 64'h0, 8'd0);
    send_request(FN_GETKEY, 32'h11, 64'h0, 8'd0);
    for (int p = 0; p < 5; p++) send_request(FN_GETPOS, 32'h0, 64'h0, p[7:0]);
    send_request(FN_GETPOS, 32'h0, 64'h0, 8'd255);
    send_request(3'd7, 32'h0, '1, 8'd0);                  // undefined code
    send_request(FN_ERASE, 32'h0, 64'h0, 8'd0);
    send_request(FN_GETPOS, 32'h0, 64'h0, 8'd0);

    // Zero capacity blocks inserts; capacity below count keeps entries.
    set_capacity(9'd0);
    send_request(FN_INSERT, 32'h42, 64'h42, 8'd0);
    send_request(FN_UPSERT, 32'h43, 64'h43, 8'd0);
    set_capacity(9'd6);
    random_phase(120, 40);
    set_capacity(9'd2);
    random_phase(60, 30);
    set_capacity(9'd1);
    random_phase(40, 30);

    // Full depth: fill past 256 with fresh keys, then exercise the big table.
    set_capacity(9'd256);
    for (int i = 0; i < 262; i++)
      send_request(FN_INSERT, $urandom(), {$urandom(), $urandom()}, 8'd0);
    for (int i = 0; i < 10; i++)
      send_request(FN_GETPOS, 32'h0, 64'h0, 8'($urandom_range(0, 255)));
    send_request(FN_GETPOS, 32'h0, 64'h0, 8'd255);
    set_capacity(9'd511);                                 // above depth
    send_request(FN_INSERT, 32'h1357, 64'h1, 8'd0);
    random_phase(100, 10);
    set_capacity(9'd128);
    random_phase(60, 10);

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
